>>> rtl/rgb_layer_blend_core_macros.svh
// Assertion macros shared by the layer blend RTL.
`ifndef RGB_LAYER_BLEND_CORE_MACROS_SVH
`define RGB_LAYER_BLEND_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk, off while rst_n is low
`define RLB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgb_layer_blend_core: assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define RLB_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgb_layer_blend_core: assertion failed");

`else

`define RLB_ASSERT_IMP(label, ante, cons)
`define RLB_ASSERT_NXT(label, ante, cons)

`endif

`endif

>>> rtl/rlb_pkg.sv
// Types and constants shared by the layer blend core and its channel datapath.
package rlb_pkg;

    localparam int CHAN_W = 8;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [1:0]        mode_t;

    // Blend mode codes held in the configuration register
    localparam mode_t MODE_MULTIPLY = 2'd0;
    localparam mode_t MODE_SUBTRACT = 2'd1;
    localparam mode_t MODE_SCREEN   = 2'd2;
    localparam mode_t MODE_OVERLAY  = 2'd3;

    localparam chan_t CHAN_MAX = 8'd255;

    // Product widths: 9-bit by 8-bit operands, plus rounding bias
    localparam int OPA_W  = CHAN_W + 1;
    localparam int PROD_W = OPA_W + CHAN_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int EST_W  = 9;

    // Half of 255, rounded down; no ties occur for integer products
    localparam logic [SUM_W-1:0] ROUND_BIAS = 18'd127;
    localparam logic [SUM_W-1:0] DIVISOR    = 18'd255;

    // Load enables for the four pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

endpackage

>>> rtl/rlb_chan.sv
// Four-stage blend datapath for one color channel.
module rlb_chan
(
    input  logic               clk,
    input  rlb_pkg::stage_en_t en,
    input  rlb_pkg::mode_t     mode,
    input  rlb_pkg::chan_t     top,
    input  rlb_pkg::chan_t     bottom,
    output rlb_pkg::chan_t     result
);

    logic [rlb_pkg::OPA_W-1:0]  opa_next;
    rlb_pkg::chan_t             opb_next;
    logic                       inv_next;
    logic                       sub_next;
    rlb_pkg::chan_t             diff_next;

    logic [rlb_pkg::OPA_W-1:0]  opa_reg;
    rlb_pkg::chan_t             opb_reg;
    logic                       inv1_reg;
    logic                       sub1_reg;
    rlb_pkg::chan_t             diff1_reg;

    logic [rlb_pkg::PROD_W-1:0] prod_reg;
    logic                       inv2_reg;
    logic                       sub2_reg;
    rlb_pkg::chan_t             diff2_reg;

    logic [rlb_pkg::SUM_W-1:0]  sum_next;
    logic [25:0]                recip_prod;
    logic [rlb_pkg::SUM_W-1:0]  sum_reg;
    logic [rlb_pkg::EST_W-1:0]  est_reg;
    logic                       inv3_reg;
    logic                       sub3_reg;
    rlb_pkg::chan_t             diff3_reg;

    logic [rlb_pkg::SUM_W-1:0]  est_times;
    logic [rlb_pkg::SUM_W-1:0]  rem;
    logic [rlb_pkg::EST_W-1:0]  quot;
    rlb_pkg::chan_t             result_next;
    rlb_pkg::chan_t             result_reg;

    // Stage 1: operand selection per mode; 255-x is the bitwise inverse
    always_comb
    begin
        diff_next = (bottom > top) ? (bottom - top) : '0;
        sub_next  = 1'b0;
        inv_next  = 1'b0;
        opa_next  = {1'b0, top};
        opb_next  = bottom;
        case (mode)
            rlb_pkg::MODE_MULTIPLY:
            begin
                opa_next = {1'b0, top};
                opb_next = bottom;
            end
            rlb_pkg::MODE_SUBTRACT:
            begin
                sub_next = 1'b1;
                opa_next = '0;
                opb_next = '0;
            end
            rlb_pkg::MODE_SCREEN:
            begin
                inv_next = 1'b1;
                opa_next = {1'b0, ~top};
                opb_next = ~bottom;
            end
            rlb_pkg::MODE_OVERLAY:
            begin
                if (!bottom[rlb_pkg::CHAN_W-1])
                begin
                    opa_next = {top, 1'b0};
                    opb_next = bottom;
                end
                else
                begin
                    inv_next = 1'b1;
                    opa_next = {~bottom, 1'b0};
                    opb_next = ~top;
                end
            end
            default:
            begin
                opa_next = {1'b0, top};
                opb_next = bottom;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            opa_reg   <= opa_next;
            opb_reg   <= opb_next;
            inv1_reg  <= inv_next;
            sub1_reg  <= sub_next;
            diff1_reg <= diff_next;
        end
    end

    // Stage 2: 9x8 product
    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            prod_reg  <= {{(rlb_pkg::PROD_W-rlb_pkg::OPA_W){1'b0}}, opa_reg}
                       * {{(rlb_pkg::PROD_W-rlb_pkg::CHAN_W){1'b0}}, opb_reg};
            inv2_reg  <= inv1_reg;
            sub2_reg  <= sub1_reg;
            diff2_reg <= diff1_reg;
        end
    end

    // Stage 3: add rounding bias, estimate sum/255 as (sum*257) >> 16
    assign sum_next   = {1'b0, prod_reg} + rlb_pkg::ROUND_BIAS;
    assign recip_prod = {sum_next, 8'd0} + {8'd0, sum_next};

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            sum_reg   <= sum_next;
            est_reg   <= recip_prod[24:16];
            inv3_reg  <= inv2_reg;
            sub3_reg  <= sub2_reg;
            diff3_reg <= diff2_reg;
        end
    end

    // Stage 4: estimate is low by at most one; fix it and form the result
    assign est_times = {1'b0, est_reg, 8'd0} - {9'd0, est_reg};
    assign rem       = sum_reg - est_times;
    assign quot      = est_reg + {{(rlb_pkg::EST_W-1){1'b0}}, (rem >= rlb_pkg::DIVISOR)};

    always_comb
    begin
        if (sub3_reg)
            result_next = diff3_reg;
        else if (inv3_reg)
            result_next = rlb_pkg::CHAN_MAX - quot[rlb_pkg::CHAN_W-1:0];
        else
            result_next = quot[rlb_pkg::CHAN_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

>>> rtl/rgb_layer_blend_core.sv
// Top level of the RGB layer blend core: handshake, mode register, valid pipeline.
//
// Blends a top pixel over a bottom pixel, per channel, in one of four modes:
// multiply, subtract, screen or overlay, chosen by the 2-bit mode register.
// Input stream (s_axis_*): one transaction carries both pixels. Output
// stream (m_axis_*): one transaction per input transaction, in order.
// Configuration (cfg_*): cfg_data is written to the mode register when
// cfg_valid is high; cfg_ready is always high. Write it only while the
// pipeline is empty.
// From the accepting edge to m_axis_tvalid, a pixel passes through the four
// register stages (operand select, multiply, reciprocal estimate,
// correction and output register), the first loading at acceptance.
// Throughput: one pixel per clock while the receiver takes data.
// Reset clears every stage valid bit and sets the mode to multiply.
// When the receiver stalls, the result is held in the output register and
// upstream stages keep filling any empty slots; s_axis_tready drops only
// once all four stages hold a pixel.
`include "rgb_layer_blend_core_macros.svh"

module rgb_layer_blend_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // top_blue, top_green, top_red, bottom_blue, bottom_green, bottom_red
    input  logic [47:0] s_axis_tdata,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_blue, out_green, out_red
    output logic [23:0] m_axis_tdata,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data
);

    localparam int STAGES = 4;

    rlb_pkg::mode_t     mode_reg;
    logic [STAGES-1:0]  valid_reg;
    logic [STAGES-1:0]  valid_next;
    logic [STAGES-1:0]  stage_ready;
    rlb_pkg::stage_en_t en;

    // Mode register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= rlb_pkg::MODE_MULTIPLY;
        else if (cfg_valid && cfg_ready)
            mode_reg <= cfg_data;
    end

    // A stage can load when it is empty or its content moves on
    assign stage_ready[3] = !valid_reg[3] || m_axis_tready;
    assign stage_ready[2] = !valid_reg[2] || stage_ready[3];
    assign stage_ready[1] = !valid_reg[1] || stage_ready[2];
    assign stage_ready[0] = !valid_reg[0] || stage_ready[1];

    assign en.s1 = stage_ready[0] && s_axis_tvalid;
    assign en.s2 = stage_ready[1] && valid_reg[0];
    assign en.s3 = stage_ready[2] && valid_reg[1];
    assign en.s4 = stage_ready[3] && valid_reg[2];

    always_comb
    begin
        valid_next[0] = stage_ready[0] ? s_axis_tvalid : valid_reg[0];
        valid_next[1] = stage_ready[1] ? valid_reg[0]  : valid_reg[1];
        valid_next[2] = stage_ready[2] ? valid_reg[1]  : valid_reg[2];
        valid_next[3] = stage_ready[3] ? valid_reg[2]  : valid_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign s_axis_tready = stage_ready[0];
    assign m_axis_tvalid = valid_reg[3];

    // Channel datapaths: blue, green, red
    rlb_chan u_blue
    (
        .clk    (clk),
        .en     (en),
        .mode   (mode_reg),
        .top    (s_axis_tdata[7:0]),
        .bottom (s_axis_tdata[31:24]),
        .result (m_axis_tdata[7:0])
    );

    rlb_chan u_green
    (
        .clk    (clk),
        .en     (en),
        .mode   (mode_reg),
        .top    (s_axis_tdata[15:8]),
        .bottom (s_axis_tdata[39:32]),
        .result (m_axis_tdata[15:8])
    );

    rlb_chan u_red
    (
        .clk    (clk),
        .en     (en),
        .mode   (mode_reg),
        .top    (s_axis_tdata[23:16]),
        .bottom (s_axis_tdata[47:40]),
        .result (m_axis_tdata[23:16])
    );

    // Checks
    `RLB_ASSERT_IMP(a_full_when_blocked, !s_axis_tready, (&valid_reg) && !m_axis_tready)
    `RLB_ASSERT_NXT(a_stall_keeps_stage3, valid_reg[3] && !m_axis_tready && valid_reg[2], valid_reg[2])
    `RLB_ASSERT_NXT(a_stage3_drains, valid_reg[2] && m_axis_tready, m_axis_tvalid)

endmodule

>>> sim/rgb_layer_blend_checker.sv
// Checker for the layer blend core: predicts each blended pixel and compares results.
`timescale 1ns / 100ps

module rgb_layer_blend_checker
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // top_blue, top_green, top_red, bottom_blue, bottom_green, bottom_red
    input  logic [47:0] s_axis_tdata,

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_blue, out_green, out_red
    input  logic [23:0] m_axis_tdata,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_data,

    output int          mismatch_count,
    output int          pixels_waiting,
    output int          pixels_checked
);

    // Blended pixel, blue in the low byte as on m_axis_tdata
    typedef struct packed {
        rlb_pkg::chan_t red;
        rlb_pkg::chan_t green;
        rlb_pkg::chan_t blue;
    } pixel_t;

    rlb_pkg::mode_t blend_mode_q;
    pixel_t         expected_pixels[$];

    // Nearest integer to x/255; 255 is odd so no tie is possible
    function automatic int unsigned div255_nearest(input int unsigned x);
        return (2 * x + 255) / 510;
    endfunction

    function automatic rlb_pkg::chan_t blend_chan(input rlb_pkg::mode_t mode,
                                                  input rlb_pkg::chan_t t,
                                                  input rlb_pkg::chan_t b);
        int unsigned tv;
        int unsigned bv;
        int unsigned r;
        tv = t;
        bv = b;
        case (mode)
            rlb_pkg::MODE_MULTIPLY: r = div255_nearest(tv * bv);
            rlb_pkg::MODE_SUBTRACT: r = (bv > tv) ? bv - tv : 0;
            rlb_pkg::MODE_SCREEN:   r = 255 - div255_nearest((255 - tv) * (255 - bv));
            default:
            begin
                // overlay: multiply below mid-gray, screen above
                if (bv <= 127)
                    r = div255_nearest(2 * tv * bv);
                else
                    r = 255 - div255_nearest(2 * (255 - bv) * (255 - tv));
            end
        endcase
        return rlb_pkg::chan_t'(r);
    endfunction

    function automatic pixel_t blend_pixel(input rlb_pkg::mode_t mode, input logic [47:0] d);
        pixel_t p;
        p.blue  = blend_chan(mode, d[7:0],   d[31:24]);
        p.green = blend_chan(mode, d[15:8],  d[39:32]);
        p.red   = blend_chan(mode, d[23:16], d[47:40]);
        return p;
    endfunction

    // Watch all three channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        pixel_t got;
        pixel_t want;
        if (!rst_n)
        begin
            blend_mode_q = rlb_pkg::MODE_MULTIPLY;
            expected_pixels.delete();
            mismatch_count = 0;
            pixels_checked = 0;
            pixels_waiting = 0;
        end
        else
        begin
            // accepted input pixel: queue its blend
            if (s_axis_tvalid && s_axis_tready)
                expected_pixels.push_back(blend_pixel(blend_mode_q, s_axis_tdata));

            // accepted result: compare with the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_pixels.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%t: unexpected result %h with nothing pending",
                                 $realtime, m_axis_tdata);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    pixels_checked++;
                    if (got.blue != want.blue || got.green != want.green
                        || got.red != want.red)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%t: pixel %0d mismatch: b/g/r exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     $realtime, pixels_checked,
                                     want.blue, want.green, want.red,
                                     got.blue, got.green, got.red);
                    end
                end
            end

            // mode register write transaction
            if (cfg_valid && cfg_ready)
                blend_mode_q = rlb_pkg::mode_t'(cfg_data);

            pixels_waiting = expected_pixels.size();
        end
    end

endmodule

>>> sim/rgb_layer_blend_core_tb.sv
// Testbench top for the layer blend core: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module rgb_layer_blend_core_tb;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_data;

    int             send_idle_pct;
    int             recv_stall_pct;
    int             pixels_sent;
    int             mismatch_count;
    int             pixels_waiting;
    int             pixels_checked;
    rlb_pkg::mode_t mode_seq[4];

    rgb_layer_blend_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    rgb_layer_blend_checker blend_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pixels_waiting (pixels_waiting),
        .pixels_checked (pixels_checked)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the pipeline hangs
    initial
    begin
        #200000;
        $display("status: fail");
        $finish;
    end

    // Receiver back-pressure
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Stop feeding and wait until every predicted pixel has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pixels_waiting != 0)
            @(negedge clk);
        // four register stages
        repeat (6) @(negedge clk);
    endtask

    // Mode register write, only with the pipeline empty
    task automatic set_blend_mode(input rlb_pkg::mode_t mode);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One input transaction carrying the top and bottom pixel
    task automatic send_pixel(input rlb_pkg::chan_t tb, input rlb_pkg::chan_t tg,
                              input rlb_pkg::chan_t tr, input rlb_pkg::chan_t bb,
                              input rlb_pkg::chan_t bg, input rlb_pkg::chan_t br);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {br, bg, bb, tr, tg, tb};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        pixels_sent++;
    endtask

    // Channel value biased toward the ends and the overlay split point
    function automatic rlb_pkg::chan_t rand_chan();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd127;
            3:       return 8'd128;
            default: return rlb_pkg::chan_t'($urandom_range(255));
        endcase
    endfunction

    // Random pixels in the current mode, with one full drain halfway
    task automatic send_random_run(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                wait_drained();
            send_pixel(rand_chan(), rand_chan(), rand_chan(),
                       rand_chan(), rand_chan(), rand_chan());
        end
    endtask

    initial
    begin
        int directed_cnt;
        rlb_pkg::mode_t mode;

        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        cfg_valid      = 1'b0;
        cfg_data       = rlb_pkg::MODE_MULTIPLY;
        send_idle_pct  = 13;
        recv_stall_pct = 74;
        pixels_sent    = 0;
        mode_seq       = '{rlb_pkg::MODE_MULTIPLY, rlb_pkg::MODE_SUBTRACT,
                           rlb_pkg::MODE_SCREEN, rlb_pkg::MODE_OVERLAY};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed corners in every mode
        for (int k = 0; k < 4; k++)
        begin
            set_blend_mode(mode_seq[k]);
            send_pixel(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
            send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
            send_pixel(8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255);
            // overlay split: bottom at 127 and 128
            send_pixel(8'd100, 8'd200, 8'd50,  8'd127, 8'd128, 8'd127);
            // subtract: bottom above, equal to, below top
            send_pixel(8'd10,  8'd128, 8'd200, 8'd20,  8'd128, 8'd100);
            send_pixel(8'd1,   8'd254, 8'd170, 8'd254, 8'd1,   8'd85);
        end
        directed_cnt = pixels_sent;

        // Random phases: sender-light/receiver-heavy, swapped, then none
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct  = (ph == 0) ? 13 : (ph == 1) ? 74 : 0;
            recv_stall_pct = (ph == 0) ? 74 : (ph == 1) ? 13 : 0;
            for (int k = 0; k < 4; k++)
            begin
                mode = (ph == 2) ? mode_seq[3 - k] : mode_seq[(k + ph) % 4];
                set_blend_mode(mode);
                send_random_run(54);
            end
        end

        wait_drained();

        $display("Checked %0d blended pixels (%0d directed, %0d random) in all four modes,",
                 pixels_checked, directed_cnt, pixels_sent - directed_cnt);
        $display("with sender and receiver stalls in turn, then at full rate.");
        if (mismatch_count == 0 && pixels_waiting == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
